FILE: design/rfaw_pkg.sv
package rfaw_pkg;

  localparam int unsigned MAX_DIM        = 4096;
  localparam int unsigned COEF_FRAC_BITS = 16;

  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PITCH_W = 15;
  localparam int unsigned SURF_W  = 13;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned SUM_W   = COEF_FRAC_BITS + 11;

  // BT.601 coefficients, scaled and rounded to nearest
  localparam logic [63:0] DEN  = 64'd100000000000;
  localparam logic [63:0] HALF = 64'd50000000000;
  localparam logic signed [SUM_W-1:0] K_YR =
    SUM_W'(((64'd25678906250 << COEF_FRAC_BITS) + HALF) / DEN);
  localparam logic signed [SUM_W-1:0] K_YG =
    SUM_W'(((64'd50412890625 << COEF_FRAC_BITS) + HALF) / DEN);
  localparam logic signed [SUM_W-1:0] K_YB =
    SUM_W'(((64'd9790625000 << COEF_FRAC_BITS) + HALF) / DEN);
  localparam logic signed [SUM_W-1:0] K_BR =
    SUM_W'(((64'd14822265625 << COEF_FRAC_BITS) + HALF) / DEN);
  localparam logic signed [SUM_W-1:0] K_BG =
    SUM_W'(((64'd29099218750 << COEF_FRAC_BITS) + HALF) / DEN);
  localparam logic signed [SUM_W-1:0] K_BB =
    SUM_W'(((64'd43921484375 << COEF_FRAC_BITS) + HALF) / DEN);
  localparam logic signed [SUM_W-1:0] K_RR =
    SUM_W'(((64'd43921484375 << COEF_FRAC_BITS) + HALF) / DEN);
  localparam logic signed [SUM_W-1:0] K_RG =
    SUM_W'(((64'd36778906250 << COEF_FRAC_BITS) + HALF) / DEN);
  localparam logic signed [SUM_W-1:0] K_RB =
    SUM_W'(((64'd7142578125 << COEF_FRAC_BITS) + HALF) / DEN);
  localparam logic signed [SUM_W-1:0] OFS_16  = SUM_W'(64'd16 << COEF_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] OFS_128 = SUM_W'(64'd128 << COEF_FRAC_BITS);

  typedef enum logic [1:0] {
    FMT_ARGB = 2'd0,
    FMT_RGBA = 2'd1,
    FMT_NV12 = 2'd2,
    FMT_NV21 = 2'd3
  } fmt_t;

  typedef enum logic [2:0] {
    REG_PIXEL_FORMAT   = 3'd0,
    REG_SURFACE_WIDTH  = 3'd1,
    REG_SURFACE_HEIGHT = 3'd2,
    REG_ROW_PITCH      = 3'd3,
    REG_BUFFER_BASE    = 3'd4,
    REG_FILL_COLOR     = 3'd5,
    REG_RECT_ORIGIN    = 3'd6,
    REG_RECT_SIZE      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    fmt_t                pixel_format;
    logic [SURF_W-1:0]   surface_width;
    logic [SURF_W-1:0]   surface_height;
    logic [PITCH_W-1:0]  row_pitch;
    logic [ADDR_W-1:0]   buffer_base;
    logic [DATA_W-1:0]   fill_color;
    logic [31:0]         rect_origin;
    logic [31:0]         rect_size;
  } cfg_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
  } ycc_t;

  typedef struct packed {
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic             last;
    ycc_t             ycc;
  } pix_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [DATA_W-1:0] pixel_data;
    logic [3:0]        byte_enable;
    logic              chroma_write;
    logic [ADDR_W-1:0] chroma_address;
    logic [15:0]       chroma_data;
    logic              last_pixel;
  } res_t;

endpackage

FILE: design/rfaw_if.sv
interface rfaw_in_if;
  logic valid;
  logic ready;
  logic start_fill;

  modport source (output valid, output start_fill, input ready);
  modport sink   (input valid, input start_fill, output ready);
endinterface

interface rfaw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_address;
  logic [31:0] pixel_data;
  logic [3:0]  byte_enable;
  logic        chroma_write;
  logic [31:0] chroma_address;
  logic [15:0] chroma_data;
  logic        last_pixel;

  modport source (output valid, output pixel_address, output pixel_data,
                  output byte_enable, output chroma_write, output chroma_address,
                  output chroma_data, output last_pixel, input ready);
  modport sink   (input valid, input pixel_address, input pixel_data,
                  input byte_enable, input chroma_write, input chroma_address,
                  input chroma_data, input last_pixel, output ready);
endinterface

FILE: design/rect_fill_address_walker_top.sv
// Solid-fill address walker: one pixel write out for each input item that lands in a fill.
// An accepted item's result passes through the walker, product and result registers in turn.
// Throughput: one item per cycle; each stage holds only while the stage after it is full and
// stalled, so bubbles close up behind a waiting result. The row*pitch products get a stage
// of their own, which adds a register stage but costs no throughput.
// Reset: synchronous, active low; clears registers, walker and valid bits; engine left idle.
module rect_fill_address_walker_top (
  input  logic                          clk,
  input  logic                          rst_n,
  rfaw_in_if.sink                       in_ch,
  rfaw_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [rfaw_pkg::CFG_W-1:0]    cfg_wdata
);
  import rfaw_pkg::*;

  // Configuration registers; the walker latches bounds and Y/Cb/Cr at start,
  // everything else is read live for each pixel.
  cfg_t cfg_r, cfg_nxt;

  ycc_t ycc;
  logic pix_valid, pix_ready;
  pix_t pix;
  logic res_valid;
  res_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PIXEL_FORMAT:   cfg_nxt.pixel_format   = fmt_t'(cfg_wdata[1:0]);
        REG_SURFACE_WIDTH:  cfg_nxt.surface_width  = cfg_wdata[SURF_W-1:0];
        REG_SURFACE_HEIGHT: cfg_nxt.surface_height = cfg_wdata[SURF_W-1:0];
        REG_ROW_PITCH:      cfg_nxt.row_pitch      = cfg_wdata[PITCH_W-1:0];
        REG_BUFFER_BASE:    cfg_nxt.buffer_base    = cfg_wdata[ADDR_W-1:0];
        REG_FILL_COLOR:     cfg_nxt.fill_color     = cfg_wdata[DATA_W-1:0];
        REG_RECT_ORIGIN:    cfg_nxt.rect_origin    = cfg_wdata[31:0];
        REG_RECT_SIZE:      cfg_nxt.rect_size      = cfg_wdata[31:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Colour conversion runs off the live fill colour; the walker samples it on start.
  rfaw_ycc u_ycc (
    .fill_color (cfg_r.fill_color),
    .ycc        (ycc)
  );

  // Clip, hold the walk position and issue one pixel per accepted item while a fill is active.
  rfaw_walker u_walker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .ycc_in        (ycc),
    .in_valid      (in_ch.valid),
    .in_start_fill (in_ch.start_fill),
    .in_ready      (in_ch.ready),
    .pix_valid     (pix_valid),
    .pix           (pix),
    .pix_ready     (pix_ready)
  );

  // Form addresses and write data for the chosen format.
  rfaw_addr u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pix_ready (pix_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (out_ch.ready)
  );

  assign out_ch.valid          = res_valid;
  assign out_ch.pixel_address  = res.pixel_address;
  assign out_ch.pixel_data     = res.pixel_data;
  assign out_ch.byte_enable    = res.byte_enable;
  assign out_ch.chroma_write   = res.chroma_write;
  assign out_ch.chroma_address = res.chroma_address;
  assign out_ch.chroma_data    = res.chroma_data;
  assign out_ch.last_pixel     = res.last_pixel;
endmodule

FILE: design/rfaw_ycc.sv
module rfaw_ycc (
  input  logic [31:0]   fill_color,
  output rfaw_pkg::ycc_t ycc
);
  import rfaw_pkg::*;

  logic signed [SUM_W-1:0] r_s, g_s, b_s;
  logic signed [SUM_W-1:0] y_sum, cb_sum, cr_sum;

  function automatic logic [7:0] sat_byte(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] q;
    q = v >>> COEF_FRAC_BITS;
    if (v <= 0) return 8'd0;
    else if (q >= 255) return 8'd255;
    else return q[7:0];
  endfunction

  assign r_s = SUM_W'(fill_color[23:16]);
  assign g_s = SUM_W'(fill_color[15:8]);
  assign b_s = SUM_W'(fill_color[7:0]);

  assign y_sum  = OFS_16  + K_YR * r_s + K_YG * g_s + K_YB * b_s;
  assign cb_sum = OFS_128 - K_BR * r_s - K_BG * g_s + K_BB * b_s;
  assign cr_sum = OFS_128 + K_RR * r_s - K_RG * g_s - K_RB * b_s;

  assign ycc.y  = sat_byte(y_sum);
  assign ycc.cb = sat_byte(cb_sum);
  assign ycc.cr = sat_byte(cr_sum);
endmodule

FILE: design/rfaw_walker.sv
module rfaw_walker (
  input  logic            clk,
  input  logic            rst_n,
  input  rfaw_pkg::cfg_t  cfg,
  input  rfaw_pkg::ycc_t  ycc_in,
  input  logic            in_valid,
  input  logic            in_start_fill,
  output logic            in_ready,
  output logic            pix_valid,
  output rfaw_pkg::pix_t  pix,
  input  logic            pix_ready
);
  import rfaw_pkg::*;

  logic [DIM_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [DIM_W-1:0] end_col_r, end_col_nxt, end_row_r, end_row_nxt;
  logic [DIM_W-1:0] left_r, left_nxt;
  logic             active_r, active_nxt;
  ycc_t             ycc_r, ycc_nxt;
  logic             pix_valid_r, pix_valid_nxt;
  pix_t             pix_r, pix_nxt;

  logic             accept, start, start_ok, emit, last;
  logic [15:0]      org_x, org_y;
  logic [DIM_W-1:0] clip_x, clip_y;
  logic [DIM_W:0]   col_inc, row_inc;

  function automatic logic [DIM_W-1:0] clip_end(input logic [15:0] org,
                                                 input logic [15:0] size,
                                                 input logic [SURF_W-1:0] surf);
    logic [16:0] e;
    e = {1'b0, org} + {1'b0, size};
    if (e > 17'(surf)) e = 17'(surf);
    if (e > 17'(MAX_DIM)) e = 17'(MAX_DIM);
    return e[DIM_W-1:0];
  endfunction

  assign in_ready = !pix_valid_r || pix_ready;
  assign accept   = in_valid && in_ready;
  assign start    = accept && in_start_fill;

  assign org_x    = cfg.rect_origin[15:0];
  assign org_y    = cfg.rect_origin[31:16];
  assign clip_x   = clip_end(org_x, cfg.rect_size[15:0], cfg.surface_width);
  assign clip_y   = clip_end(org_y, cfg.rect_size[31:16], cfg.surface_height);
  assign start_ok = (org_x < 16'(clip_x)) && (org_y < 16'(clip_y));

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    end_col_nxt   = end_col_r;
    end_row_nxt   = end_row_r;
    left_nxt      = left_r;
    active_nxt    = active_r;
    ycc_nxt       = ycc_r;
    pix_valid_nxt = pix_valid_r && !pix_ready;
    pix_nxt       = pix_r;

    // load a new rectangle on start
    if (start) begin
      ycc_nxt    = ycc_in;
      active_nxt = start_ok;
      if (start_ok) begin
        col_nxt     = org_x[DIM_W-1:0];
        left_nxt    = org_x[DIM_W-1:0];
        row_nxt     = org_y[DIM_W-1:0];
        end_col_nxt = clip_x;
        end_row_nxt = clip_y;
      end
    end

    emit    = accept && active_nxt;
    col_inc = {1'b0, col_nxt} + 1'b1;
    row_inc = {1'b0, row_nxt} + 1'b1;
    last    = (col_inc == {1'b0, end_col_nxt}) && (row_inc == {1'b0, end_row_nxt});

    if (in_ready) begin
      pix_valid_nxt = emit;
    end

    if (emit) begin
      pix_nxt.col  = col_nxt;
      pix_nxt.row  = row_nxt;
      pix_nxt.last = last;
      pix_nxt.ycc  = ycc_nxt;
      // advance the walk
      if (last) begin
        active_nxt = 1'b0;
      end else if (col_inc >= {1'b0, end_col_nxt}) begin
        col_nxt = left_nxt;
        row_nxt = row_inc[DIM_W-1:0];
      end else begin
        col_nxt = col_inc[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      end_col_r   <= '0;
      end_row_r   <= '0;
      left_r      <= '0;
      active_r    <= 1'b0;
      ycc_r       <= '0;
      pix_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      end_col_r   <= end_col_nxt;
      end_row_r   <= end_row_nxt;
      left_r      <= left_nxt;
      active_r    <= active_nxt;
      ycc_r       <= ycc_nxt;
      pix_valid_r <= pix_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign pix_valid = pix_valid_r;
  assign pix       = pix_r;
endmodule

FILE: design/rfaw_addr.sv
module rfaw_addr (
  input  logic            clk,
  input  logic            rst_n,
  input  rfaw_pkg::cfg_t  cfg,
  input  logic            pix_valid,
  input  rfaw_pkg::pix_t  pix,
  output logic            pix_ready,
  output logic            res_valid,
  output rfaw_pkg::res_t  res,
  input  logic            res_ready
);
  import rfaw_pkg::*;

  localparam int unsigned RPROD_W = DIM_W + PITCH_W;
  localparam int unsigned CPROD_W = SURF_W + 1 + PITCH_W;

  // product stage
  logic               mul_valid_r, mul_valid_nxt;
  pix_t               mul_pix_r;
  logic [RPROD_W-1:0] row_prod_r;
  logic [CPROD_W-1:0] chroma_prod_r;
  logic               mul_ready;

  // result stage
  logic               res_valid_r, res_valid_nxt;
  res_t               res_r, res_nxt;
  logic               res_take;

  logic [SURF_W:0]    chroma_row;
  logic [ADDR_W-1:0]  col_ext;

  assign res_take  = !res_valid_r || res_ready;
  assign mul_ready = res_take;
  assign pix_ready = !mul_valid_r || mul_ready;

  assign chroma_row    = {1'b0, cfg.surface_height} + (SURF_W + 1)'(pix.row >> 1);
  assign mul_valid_nxt = pix_ready ? pix_valid : mul_valid_r;

  always_ff @(posedge clk) begin
    if (pix_ready) begin
      mul_pix_r     <= pix;
      row_prod_r    <= RPROD_W'(pix.row) * RPROD_W'(cfg.row_pitch);
      chroma_prod_r <= CPROD_W'(chroma_row) * CPROD_W'(cfg.row_pitch);
    end
  end

  assign col_ext = ADDR_W'(mul_pix_r.col);

  always_comb begin
    res_nxt       = res_r;
    res_valid_nxt = res_take ? mul_valid_r : res_valid_r;
    if (res_take) begin
      res_nxt.last_pixel = mul_pix_r.last;
      unique case (cfg.pixel_format)
        FMT_ARGB: begin
          res_nxt.pixel_address  = cfg.buffer_base + ADDR_W'(row_prod_r) + (col_ext << 2);
          res_nxt.pixel_data     = cfg.fill_color;
          res_nxt.byte_enable    = 4'hF;
          res_nxt.chroma_write   = 1'b0;
          res_nxt.chroma_address = '0;
          res_nxt.chroma_data    = '0;
        end
        FMT_RGBA: begin
          res_nxt.pixel_address  = cfg.buffer_base + ADDR_W'(row_prod_r) + (col_ext << 2);
          res_nxt.pixel_data     = {cfg.fill_color[31:24], cfg.fill_color[7:0],
                                    cfg.fill_color[15:8], cfg.fill_color[23:16]};
          res_nxt.byte_enable    = 4'hF;
          res_nxt.chroma_write   = 1'b0;
          res_nxt.chroma_address = '0;
          res_nxt.chroma_data    = '0;
        end
        FMT_NV12: begin
          res_nxt.pixel_address  = cfg.buffer_base + ADDR_W'(row_prod_r) + col_ext;
          res_nxt.pixel_data     = DATA_W'(mul_pix_r.ycc.y);
          res_nxt.byte_enable    = 4'h1;
          res_nxt.chroma_write   = 1'b1;
          res_nxt.chroma_address = cfg.buffer_base + ADDR_W'(chroma_prod_r)
                                   + {col_ext[ADDR_W-1:1], 1'b0};
          res_nxt.chroma_data    = {mul_pix_r.ycc.cr, mul_pix_r.ycc.cb};
        end
        FMT_NV21: begin
          res_nxt.pixel_address  = cfg.buffer_base + ADDR_W'(row_prod_r) + col_ext;
          res_nxt.pixel_data     = DATA_W'(mul_pix_r.ycc.y);
          res_nxt.byte_enable    = 4'h1;
          res_nxt.chroma_write   = 1'b1;
          res_nxt.chroma_address = cfg.buffer_base + ADDR_W'(chroma_prod_r)
                                   + {col_ext[ADDR_W-1:1], 1'b0};
          res_nxt.chroma_data    = {mul_pix_r.ycc.cb, mul_pix_r.ycc.cr};
        end
        default: begin
          res_nxt = res_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= mul_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;
endmodule

FILE: tb/tb_rect_fill_address_walker_top.sv
`timescale 1ns / 100ps

module tb_rect_fill_address_walker_top;
  import rfaw_pkg::*;

  // Three register stages from item to pixel write; allow a few more for settling.
  localparam int unsigned PIPE_DEPTH    = 3;
  localparam int unsigned SETTLE_CYCLES = PIPE_DEPTH + 3;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 1900;

  // BT.601 weights, scaled by 2^COEF_FRAC_BITS and rounded to nearest
  localparam longint unsigned W_SCALE = 64'd100000000000;
  localparam longint unsigned W_HALF  = 64'd50000000000;
  localparam longint Y_FROM_R  = ((64'd25678906250 << COEF_FRAC_BITS) + W_HALF) / W_SCALE;
  localparam longint Y_FROM_G  = ((64'd50412890625 << COEF_FRAC_BITS) + W_HALF) / W_SCALE;
  localparam longint Y_FROM_B  = ((64'd9790625000 << COEF_FRAC_BITS) + W_HALF) / W_SCALE;
  localparam longint CB_FROM_R = ((64'd14822265625 << COEF_FRAC_BITS) + W_HALF) / W_SCALE;
  localparam longint CB_FROM_G = ((64'd29099218750 << COEF_FRAC_BITS) + W_HALF) / W_SCALE;
  localparam longint CB_FROM_B = ((64'd43921484375 << COEF_FRAC_BITS) + W_HALF) / W_SCALE;
  localparam longint CR_FROM_R = ((64'd43921484375 << COEF_FRAC_BITS) + W_HALF) / W_SCALE;
  localparam longint CR_FROM_G = ((64'd36778906250 << COEF_FRAC_BITS) + W_HALF) / W_SCALE;
  localparam longint CR_FROM_B = ((64'd7142578125 << COEF_FRAC_BITS) + W_HALF) / W_SCALE;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  rfaw_in_if  in_ch ();
  rfaw_out_if out_ch ();

  rect_fill_address_walker_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the registers and the walker state
  // ---------------------------------------------------------------------------
  fmt_t        cfg_fmt = FMT_ARGB;
  logic [12:0] cfg_surf_w = '0;
  logic [12:0] cfg_surf_h = '0;
  logic [14:0] cfg_pitch = '0;
  logic [31:0] cfg_base = '0;
  logic [31:0] cfg_colour = '0;
  logic [31:0] cfg_origin = '0;
  logic [31:0] cfg_size = '0;

  int unsigned cur_col = 0, cur_row = 0, end_col = 0, end_row = 0, left_col = 0;
  bit          fill_on = 1'b0;
  logic [7:0]  luma_q = '0, cb_q = '0, cr_q = '0;

  res_t        pending_writes[$];

  // Raw values last written to each register, upper junk bits included
  logic [31:0] reg_val [8] = '{default: '0};

  int unsigned items_sent = 0;
  int unsigned writes_checked = 0;
  int unsigned chroma_checked = 0;
  int unsigned fills_done = 0;
  int unsigned settings_used = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int          burst_left = 0;

  function automatic logic [7:0] clamp_byte(longint v);
    if (v <= 0) return 8'd0;
    if ((v >>> COEF_FRAC_BITS) >= 255) return 8'hFF;
    return 8'(v >>> COEF_FRAC_BITS);
  endfunction

  function automatic void latch_ycbcr();
    longint r, g, b, one;
    r   = longint'(cfg_colour[23:16]);
    g   = longint'(cfg_colour[15:8]);
    b   = longint'(cfg_colour[7:0]);
    one = longint'(1) << COEF_FRAC_BITS;
    luma_q = clamp_byte(16 * one + Y_FROM_R * r + Y_FROM_G * g + Y_FROM_B * b);
    cb_q   = clamp_byte(128 * one - CB_FROM_R * r - CB_FROM_G * g + CB_FROM_B * b);
    cr_q   = clamp_byte(128 * one + CR_FROM_R * r - CR_FROM_G * g - CR_FROM_B * b);
  endfunction

  function automatic int unsigned clip_bound(int unsigned start, int unsigned extent,
                                             int unsigned surf);
    int unsigned e;
    e = start + extent;
    if (e > surf) e = surf;
    if (e > MAX_DIM) e = MAX_DIM;
    return e;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] d);
    case (cfg_reg_t'(idx))
      REG_PIXEL_FORMAT:   cfg_fmt    = fmt_t'(d[1:0]);
      REG_SURFACE_WIDTH:  cfg_surf_w = d[12:0];
      REG_SURFACE_HEIGHT: cfg_surf_h = d[12:0];
      REG_ROW_PITCH:      cfg_pitch  = d[14:0];
      REG_BUFFER_BASE:    cfg_base   = d;
      REG_FILL_COLOR:     cfg_colour = d;
      REG_RECT_ORIGIN:    cfg_origin = d;
      REG_RECT_SIZE:      cfg_size   = d;
      default: ;
    endcase
  endfunction

  // One accepted item: latch a new fill on start, then emit the pixel at the cursor.
  function automatic void predict_fill_step(bit start);
    int unsigned x, y, ex, ey, col, row;
    bit          is_last;
    res_t        w;
    if (start) begin
      x  = cfg_origin[15:0];
      y  = cfg_origin[31:16];
      ex = clip_bound(x, cfg_size[15:0], cfg_surf_w);
      ey = clip_bound(y, cfg_size[31:16], cfg_surf_h);
      latch_ycbcr();
      fill_on = (x < ex) && (y < ey);
      if (fill_on) begin
        cur_col  = x;
        left_col = x;
        cur_row  = y;
        end_col  = ex;
        end_row  = ey;
      end
    end
    if (!fill_on) return;

    col     = cur_col;
    row     = cur_row;
    is_last = (col + 1 == end_col) && (row + 1 == end_row);
    w       = '0;
    if (cfg_fmt == FMT_ARGB || cfg_fmt == FMT_RGBA) begin
      w.pixel_address = cfg_base + row * cfg_pitch + col * 4;
      w.pixel_data    = (cfg_fmt == FMT_ARGB) ? cfg_colour :
                        {cfg_colour[31:24], cfg_colour[7:0], cfg_colour[15:8],
                         cfg_colour[23:16]};
      w.byte_enable   = 4'hF;
    end else begin
      // Chroma plane follows the luma plane; one Cb/Cr pair per even column
      w.pixel_address  = cfg_base + row * cfg_pitch + col;
      w.pixel_data     = {24'd0, luma_q};
      w.byte_enable    = 4'h1;
      w.chroma_write   = 1'b1;
      w.chroma_address = cfg_base + cfg_surf_h * cfg_pitch + (row >> 1) * cfg_pitch
                         + (col & ~32'd1);
      w.chroma_data    = (cfg_fmt == FMT_NV12) ? {cr_q, cb_q} : {cb_q, cr_q};
    end
    w.last_pixel = is_last;
    pending_writes.push_back(w);

    if (is_last) begin
      fill_on = 1'b0;
    end else if (col + 1 >= end_col) begin
      cur_col = left_col;
      cur_row = row + 1;
    end else begin
      cur_col = col + 1;
    end
  endfunction

  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (got === want) return 0;
    $error("%s: expected %h, got %h", name, want, got);
    return 1;
  endfunction

  function automatic void check_pixel_write();
    res_t want;
    if (pending_writes.size() == 0) begin
      $error("pixel write to %h with none expected", out_ch.pixel_address);
      errors++;
      return;
    end
    want = pending_writes.pop_front();
    errors += field_diff("pixel_address", want.pixel_address, out_ch.pixel_address);
    errors += field_diff("pixel_data", want.pixel_data, out_ch.pixel_data);
    errors += field_diff("byte_enable", 32'(want.byte_enable), 32'(out_ch.byte_enable));
    errors += field_diff("chroma_write", 32'(want.chroma_write), 32'(out_ch.chroma_write));
    errors += field_diff("chroma_address", want.chroma_address, out_ch.chroma_address);
    errors += field_diff("chroma_data", 32'(want.chroma_data), 32'(out_ch.chroma_data));
    errors += field_diff("last_pixel", 32'(want.last_pixel), 32'(out_ch.last_pixel));
    writes_checked++;
    if (want.chroma_write) chroma_checked++;
    if (want.last_pixel) fills_done++;
  endfunction

  // Sample both channels and the register port at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready) predict_fill_step(in_ch.start_fill);
      if (out_ch.valid && out_ch.ready) check_pixel_write();
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Write side back-pressure: switch between free flow, light and heavy random
  // stalls, and long blocks of stall and flow.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_mode_left = 0;
  int block_left = 0;
  bit block_level = 1'b1;

  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(20, 200);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (block_left == 0) begin
          block_level = !block_level;
          block_left  = $urandom_range(1, 15);
        end else begin
          block_left--;
        end
        out_ch.ready <= block_level;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Drivers: all called and returning at a falling edge
  // ---------------------------------------------------------------------------

  // Send one item; between bursts drop valid for a random gap.
  task automatic send_item(input bit start);
    in_ch.start_fill <= start;
    in_ch.valid      <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) :
                                                 $urandom_range(0, 10);
    end
  endtask

  // Advance until the walker has issued its final pixel.
  task automatic finish_fill();
    while (fill_on) send_item(1'b0);
  endtask

  // Hold the sender, wait for every expected write, then let the pipe empty.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the selected registers back to back from reg_val.
  task automatic load_regs(input logic [7:0] sel);
    for (int i = 0; i < 8; i++) begin
      if (sel[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= 3'(i);
        cfg_wdata <= reg_val[i];
        @(negedge clk);
      end
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] with_junk(logic [31:0] v, int unsigned width);
    if ($urandom_range(0, 7) == 0) return v | ($urandom << width);
    return v;
  endfunction

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 32'd0;
      1:       return 32'h1FFF;
      2:       return MAX_DIM;
      3:       return $urandom_range(MAX_DIM + 1, 8190);
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  // Start and extent along one axis, packed as {extent, start}; keep the clipped span short.
  function automatic logic [31:0] pick_span(int unsigned lim, int unsigned longest);
    logic [15:0] s, e;
    if (lim == 0) begin
      s = $urandom_range(0, 20);
      e = $urandom_range(0, longest);
    end else begin
      case ($urandom_range(0, 14))
        0: begin
          s = $urandom_range(lim, 16'hFFFF);
          e = $urandom_range(0, longest);
        end
        1: begin
          s = $urandom_range(0, lim - 1);
          e = '0;
        end
        2, 3, 4: begin
          // hug the right or bottom edge and overrun it
          s = lim - $urandom_range(1, (lim < 6) ? lim : 6);
          e = $urandom_range(lim - s, 16'hFFFF);
        end
        default: begin
          s = $urandom_range(0, lim - 1);
          e = $urandom_range(1, longest);
        end
      endcase
    end
    return {e, s};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers still at reset: the rectangle is empty, so neither start nor advance writes.
  task automatic test_idle_engine();
    send_item(1'b1);
    send_item(1'b0);
  endtask

  // Packed formats on an 8x6 surface; rectangle clipped to 2x2 at the corner.
  task automatic test_packed_formats();
    wait_idle();
    reg_val[REG_PIXEL_FORMAT]   = FMT_ARGB;
    reg_val[REG_SURFACE_WIDTH]  = 32'd8;
    reg_val[REG_SURFACE_HEIGHT] = 32'd6;
    reg_val[REG_ROW_PITCH]      = 32'd64;
    reg_val[REG_BUFFER_BASE]    = 32'h1000_0000;
    reg_val[REG_FILL_COLOR]     = 32'h80FF_4020;
    reg_val[REG_RECT_ORIGIN]    = {16'd4, 16'd6};
    reg_val[REG_RECT_SIZE]      = {16'd4, 16'd4};
    load_regs(8'hFF);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    send_item(1'b0);  // past the end: walker idle

    // RGBA, restarting the fill after its second pixel
    wait_idle();
    reg_val[REG_PIXEL_FORMAT] = FMT_RGBA;
    reg_val[REG_FILL_COLOR]   = 32'hFFFF_FFFF;
    load_regs(8'b0010_0001);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
  endtask

  // NV12 over odd and even rows and columns, then a one-column NV21 strip.
  task automatic test_planar_formats();
    wait_idle();
    reg_val[REG_PIXEL_FORMAT] = FMT_NV12;
    reg_val[REG_FILL_COLOR]   = 32'h0000_0000;
    reg_val[REG_RECT_ORIGIN]  = {16'd1, 16'd1};
    reg_val[REG_RECT_SIZE]    = {16'd2, 16'd3};
    load_regs(8'b1110_0001);
    send_item(1'b1);
    repeat (5) send_item(1'b0);

    wait_idle();
    reg_val[REG_PIXEL_FORMAT] = FMT_NV21;
    reg_val[REG_FILL_COLOR]   = 32'h00FF_FF00;
    reg_val[REG_RECT_ORIGIN]  = {16'd0, 16'd0};
    reg_val[REG_RECT_SIZE]    = {16'd3, 16'd1};
    load_regs(8'b1110_0001);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
  endtask

  // Oversized surface clipped at MAX_DIM, widest pitch, addresses wrapping past 2^32;
  // narrow registers written with all ones to check masking.
  task automatic test_clip_and_wrap();
    wait_idle();
    reg_val[REG_PIXEL_FORMAT]   = 32'hFFFF_FFFF;
    reg_val[REG_SURFACE_WIDTH]  = 32'hFFFF_FFFF;
    reg_val[REG_SURFACE_HEIGHT] = 32'hFFFF_FFFF;
    reg_val[REG_ROW_PITCH]      = 32'hFFFF_FFFF;
    reg_val[REG_BUFFER_BASE]    = 32'hFFFF_FF00;
    reg_val[REG_FILL_COLOR]     = 32'h7F12_80EE;
    reg_val[REG_RECT_ORIGIN]    = {16'd4095, 16'd4094};
    reg_val[REG_RECT_SIZE]      = 32'hFFFF_FFFF;
    load_regs(8'hFF);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  // Random settings, each followed by mostly complete fills, some restarts and noise.
  task automatic test_random_fills();
    int unsigned stop_at, lim_w, lim_h;
    logic [31:0] xs, ys;
    logic [7:0]  sel;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      wait_idle();
      sel = $urandom_range(0, 255);
      sel[REG_RECT_ORIGIN] = 1'b1;
      sel[REG_RECT_SIZE]   = 1'b1;
      reg_val[REG_PIXEL_FORMAT]   = with_junk($urandom_range(0, 3), 2);
      reg_val[REG_SURFACE_WIDTH]  = with_junk(pick_dim(), 13);
      reg_val[REG_SURFACE_HEIGHT] = with_junk(pick_dim(), 13);
      reg_val[REG_ROW_PITCH]      = with_junk(($urandom_range(0, 3) == 0) ?
                                              $urandom_range(0, 32767) :
                                              $urandom_range(1, 300), 15);
      reg_val[REG_BUFFER_BASE]    = ($urandom_range(0, 5) == 0) ?
                                    (32'hFFFF_F000 | $urandom_range(0, 4095)) : $urandom;
      case ($urandom_range(0, 7))
        0:       reg_val[REG_FILL_COLOR] = 32'h0000_0000;
        1:       reg_val[REG_FILL_COLOR] = 32'hFFFF_FFFF;
        default: reg_val[REG_FILL_COLOR] = $urandom;
      endcase
      // Rectangle is always rewritten, shaped against whatever surface will be live
      lim_w = (reg_val[REG_SURFACE_WIDTH][12:0] > MAX_DIM) ? MAX_DIM :
              reg_val[REG_SURFACE_WIDTH][12:0];
      lim_h = (reg_val[REG_SURFACE_HEIGHT][12:0] > MAX_DIM) ? MAX_DIM :
              reg_val[REG_SURFACE_HEIGHT][12:0];
      if (!sel[REG_SURFACE_WIDTH]) lim_w = (cfg_surf_w > MAX_DIM) ? MAX_DIM : cfg_surf_w;
      if (!sel[REG_SURFACE_HEIGHT]) lim_h = (cfg_surf_h > MAX_DIM) ? MAX_DIM : cfg_surf_h;
      xs = pick_span(lim_w, 8);
      ys = pick_span(lim_h, 6);
      reg_val[REG_RECT_ORIGIN] = {ys[15:0], xs[15:0]};
      reg_val[REG_RECT_SIZE]   = {ys[31:16], xs[31:16]};
      // Unselected registers keep their live value in reg_val
      if (!sel[REG_PIXEL_FORMAT])   reg_val[REG_PIXEL_FORMAT]   = 32'(cfg_fmt);
      if (!sel[REG_SURFACE_WIDTH])  reg_val[REG_SURFACE_WIDTH]  = 32'(cfg_surf_w);
      if (!sel[REG_SURFACE_HEIGHT]) reg_val[REG_SURFACE_HEIGHT] = 32'(cfg_surf_h);
      if (!sel[REG_ROW_PITCH])      reg_val[REG_ROW_PITCH]      = 32'(cfg_pitch);
      if (!sel[REG_BUFFER_BASE])    reg_val[REG_BUFFER_BASE]    = cfg_base;
      if (!sel[REG_FILL_COLOR])     reg_val[REG_FILL_COLOR]     = cfg_colour;
      load_regs(sel);

      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          send_item(1'b1);
          finish_fill();
          repeat ($urandom_range(0, 2)) send_item(1'b0);
        end
        6, 7: begin
          // abandon the running fill part-way and start over
          send_item(1'b1);
          repeat ($urandom_range(0, 3)) send_item(1'b0);
          send_item(1'b1);
          finish_fill();
        end
        8: begin
          repeat ($urandom_range(3, 12)) send_item($urandom_range(0, 3) == 0);
          finish_fill();
        end
        default: begin
          repeat (2) begin
            send_item(1'b1);
            finish_fill();
          end
        end
      endcase
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.start_fill = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_engine();
    test_packed_formats();
    test_planar_formats();
    test_clip_and_wrap();
    test_random_fills();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0) begin
      $error("%0d pixel writes never arrived", pending_writes.size());
      errors++;
    end

    $display("Sent %0d items under %0d register settings in all four pixel formats.",
             items_sent, settings_used);
    $display("Checked %0d pixel writes, %0d with a chroma pair; %0d fills ran to the end.",
             writes_checked, chroma_checked, fills_done);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
